// ===== rtl/nns_pkg.sv =====
// ----------------------------------------------------------------------------
// nns_pkg
// Shared types and fixed widths of the nearest-neighbour scaler.
// ----------------------------------------------------------------------------
package nns_pkg;

   localparam int SRC_W   = 9;
   localparam int DST_W   = 13;
   localparam int COORD_W = 12;
   localparam int CH_W    = 8;
   localparam int PIX_W   = 3 * CH_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DST_W;

   localparam int NUM_W = SRC_W + DST_W + 2;
   localparam int DIV_W = DST_W + 1;
   localparam int CNT_W = $clog2(SRC_W);

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_FETCH = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_ROWS = 2'd0,
      CSR_SRC_COLS = 2'd1,
      CSR_DST_ROWS = 2'd2,
      CSR_DST_COLS = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MAP_IDLE,
      MAP_MUL,
      MAP_DIV
   } map_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_ADDR,
      ST_WRITE,
      ST_READ,
      ST_DATA
   } ctl_state_type;

endpackage

// ===== rtl/nns_ram.sv =====
// ----------------------------------------------------------------------------
// nns_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module nns_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/nns_map.sv =====
// ----------------------------------------------------------------------------
// nns_map
// Bit-serial coordinate mapper: q = floor((2*d*s + dn) / (2*dn)), clamped to
// s-1. Shift-add multiply, then restoring divide, one bit per cycle each.
// ----------------------------------------------------------------------------
module nns_map (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [nns_pkg::COORD_W-1:0] d,
   input  logic [nns_pkg::SRC_W-1:0]   s,
   input  logic [nns_pkg::DST_W-1:0]   dn,
   output logic                        done,
   output logic [nns_pkg::SRC_W-1:0]   q
);

   nns_pkg::map_state_type           state_ff, state_in;
   logic [nns_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [nns_pkg::NUM_W-1:0]        acc_ff, acc_in;
   logic [nns_pkg::NUM_W-1:0]        mcand_ff, mcand_in;
   logic [nns_pkg::SRC_W-1:0]        mplier_ff, mplier_in;
   logic [nns_pkg::DIV_W-1:0]        rem_ff, rem_in;
   logic [nns_pkg::DIV_W-1:0]        dvs_ff, dvs_in;
   logic [nns_pkg::SRC_W-1:0]        nlo_ff, nlo_in;
   logic [nns_pkg::SRC_W-1:0]        quo_ff, quo_in;
   logic [nns_pkg::SRC_W-1:0]        s_ff, s_in;
   logic [nns_pkg::SRC_W-1:0]        q_ff, q_in;
   logic                             done_ff, done_in;

   logic [nns_pkg::NUM_W-1:0]        acc_sum;
   logic [nns_pkg::DIV_W:0]          trial;
   logic [nns_pkg::DIV_W:0]          diff;
   logic                             ge;
   logic [nns_pkg::SRC_W-1:0]        qfull;
   logic [nns_pkg::SRC_W-1:0]        s_max;
   logic                             last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nns_pkg::MAP_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      nlo_ff    <= nlo_in;
      quo_ff    <= quo_in;
      s_ff      <= s_in;
      q_ff      <= q_in;
   end

   always_comb begin
      acc_sum = mplier_ff[0] ? nns_pkg::NUM_W'(acc_ff + mcand_ff) : acc_ff;
      trial   = {rem_ff, nlo_ff[nns_pkg::SRC_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = trial >= {1'b0, dvs_ff};
      qfull   = {quo_ff[nns_pkg::SRC_W-2:0], ge};
      s_max   = s_ff - nns_pkg::SRC_W'(1);
      last    = cnt_ff == nns_pkg::CNT_W'(nns_pkg::SRC_W - 1);

      state_in  = state_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      nlo_in    = nlo_ff;
      quo_in    = quo_ff;
      s_in      = s_ff;
      q_in      = q_ff;
      done_in   = 1'b0;

      unique case (state_ff)
         nns_pkg::MAP_IDLE: begin
            if (start) begin
               acc_in    = nns_pkg::NUM_W'(dn);
               mcand_in  = nns_pkg::NUM_W'({d, 1'b0});
               mplier_in = s;
               s_in      = s;
               dvs_in    = {dn, 1'b0};
               cnt_in    = '0;
               state_in  = nns_pkg::MAP_MUL;
            end
         end
         nns_pkg::MAP_MUL: begin
            acc_in    = acc_sum;
            mcand_in  = {mcand_ff[nns_pkg::NUM_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[nns_pkg::SRC_W-1:1]};
            cnt_in    = cnt_ff + nns_pkg::CNT_W'(1);
            if (last) begin
               rem_in   = acc_sum[nns_pkg::NUM_W-2:nns_pkg::SRC_W];
               nlo_in   = acc_sum[nns_pkg::SRC_W-1:0];
               quo_in   = '0;
               cnt_in   = '0;
               state_in = nns_pkg::MAP_DIV;
            end
         end
         nns_pkg::MAP_DIV: begin
            rem_in = ge ? diff[nns_pkg::DIV_W-1:0] : trial[nns_pkg::DIV_W-1:0];
            nlo_in = {nlo_ff[nns_pkg::SRC_W-2:0], 1'b0};
            quo_in = qfull;
            cnt_in = cnt_ff + nns_pkg::CNT_W'(1);
            if (last) begin
               q_in     = (qfull > s_max) ? s_max : qfull;
               done_in  = 1'b1;
               state_in = nns_pkg::MAP_IDLE;
            end
         end
         default: begin
            state_in = nns_pkg::MAP_IDLE;
         end
      endcase
   end

   assign done = done_ff;
   assign q    = q_ff;

`ifndef ASSERT_OFF
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("mapper done held for more than one cycle");

   a_q_clamped: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> q_ff < s_ff)
      else $error("mapped coordinate not below source size");
`endif

endmodule

// ===== rtl/nearest_neighbor_scaler.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_scaler
// Nearest-neighbour scaler over a source frame store held in one RAM.
//
//   channel  ports                         handshake
//   request  req_*                         start & !busy
//   response rsp_*                         rsp_valid, one cycle, no stall
//   csr      csr_index, csr_data           csr_valid & csr_ready
//
// A load runs address multiply, then RAM write; a load outside the source size
// is dropped without a response. A fetch: two bit-serial mappers run side
// by side, 9 multiply steps and 9 divide steps each, a hand-over of the
// mapped coordinate, then address, RAM read, response register. A fetch outside
// the destination size is answered from idle through the response register, with rsp_coord_error set and a zero pixel.
// Synchronous reset restores the size registers; the frame store is not cleared.
// ----------------------------------------------------------------------------
module nearest_neighbor_scaler #(
   parameter int MAX_SRC_ROWS = 256,
   parameter int MAX_SRC_COLS = 256,
   parameter int MAX_DST_DIM  = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_type,
   input  logic [nns_pkg::COORD_W-1:0]    req_row,
   input  logic [nns_pkg::COORD_W-1:0]    req_col,
   input  logic [nns_pkg::CH_W-1:0]       req_pix_blue,
   input  logic [nns_pkg::CH_W-1:0]       req_pix_green,
   input  logic [nns_pkg::CH_W-1:0]       req_pix_red,
   output logic                           rsp_valid,
   output logic [nns_pkg::CH_W-1:0]       rsp_out_blue,
   output logic [nns_pkg::CH_W-1:0]       rsp_out_green,
   output logic [nns_pkg::CH_W-1:0]       rsp_out_red,
   output logic                           rsp_coord_error,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [nns_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nns_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int DEPTH  = MAX_SRC_ROWS * MAX_SRC_COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SRC_LIM = (1 << nns_pkg::SRC_W) - 1;
   localparam int DST_LIM = (1 << nns_pkg::DST_W) - 1;
   localparam int SR_CAP = (MAX_SRC_ROWS < SRC_LIM) ? MAX_SRC_ROWS : SRC_LIM;
   localparam int SC_CAP = (MAX_SRC_COLS < SRC_LIM) ? MAX_SRC_COLS : SRC_LIM;
   localparam int D_CAP  = (MAX_DST_DIM < DST_LIM) ? MAX_DST_DIM : DST_LIM;
   localparam logic [nns_pkg::SRC_W-1:0] SR_CAP_V = SR_CAP[nns_pkg::SRC_W-1:0];
   localparam logic [nns_pkg::SRC_W-1:0] SC_CAP_V = SC_CAP[nns_pkg::SRC_W-1:0];
   localparam logic [nns_pkg::DST_W-1:0] D_CAP_V  = D_CAP[nns_pkg::DST_W-1:0];
   localparam logic [ADDR_W-1:0] COLS_V = ADDR_W'(MAX_SRC_COLS);

   nns_pkg::ctl_state_type            state_ff, state_in;
   logic                              load_ff, load_in;
   logic [nns_pkg::SRC_W-1:0]         y_ff, y_in;
   logic [nns_pkg::SRC_W-1:0]         x_ff, x_in;
   logic [nns_pkg::PIX_W-1:0]         pix_ff, pix_in;
   logic [ADDR_W-1:0]                 addr_ff, addr_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [nns_pkg::PIX_W-1:0]         rsp_pix_ff, rsp_pix_in;
   logic                              rsp_err_ff, rsp_err_in;
   logic [nns_pkg::SRC_W-1:0]         src_rows_ff, src_cols_ff;
   logic [nns_pkg::DST_W-1:0]         dst_rows_ff, dst_cols_ff;

   logic [nns_pkg::SRC_W-1:0]         eff_sr, eff_sc;
   logic [nns_pkg::DST_W-1:0]         eff_dr, eff_dc;
   logic                              map_start;
   logic                              row_done, col_done;
   logic [nns_pkg::SRC_W-1:0]         row_q, col_q;
   logic                              ram_en, ram_we;
   logic [nns_pkg::PIX_W-1:0]         ram_rdata;
   logic                              load_ok, fetch_bad;

   always_comb begin
      eff_sr = (src_rows_ff == '0) ? nns_pkg::SRC_W'(1) :
               (src_rows_ff > SR_CAP_V) ? SR_CAP_V : src_rows_ff;
      eff_sc = (src_cols_ff == '0) ? nns_pkg::SRC_W'(1) :
               (src_cols_ff > SC_CAP_V) ? SC_CAP_V : src_cols_ff;
      eff_dr = (dst_rows_ff == '0) ? nns_pkg::DST_W'(1) :
               (dst_rows_ff > D_CAP_V) ? D_CAP_V : dst_rows_ff;
      eff_dc = (dst_cols_ff == '0) ? nns_pkg::DST_W'(1) :
               (dst_cols_ff > D_CAP_V) ? D_CAP_V : dst_cols_ff;
      load_ok   = (req_row < nns_pkg::COORD_W'(eff_sr)) &&
                  (req_col < nns_pkg::COORD_W'(eff_sc));
      fetch_bad = (nns_pkg::DST_W'(req_row) >= eff_dr) ||
                  (nns_pkg::DST_W'(req_col) >= eff_dc);
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_rows_ff <= nns_pkg::SRC_W'(256);
         src_cols_ff <= nns_pkg::SRC_W'(256);
         dst_rows_ff <= nns_pkg::DST_W'(256);
         dst_cols_ff <= nns_pkg::DST_W'(256);
      end else if (csr_valid && csr_ready) begin
         unique case (nns_pkg::csr_index_type'(csr_index))
            nns_pkg::CSR_SRC_ROWS: src_rows_ff <= csr_data[nns_pkg::SRC_W-1:0];
            nns_pkg::CSR_SRC_COLS: src_cols_ff <= csr_data[nns_pkg::SRC_W-1:0];
            nns_pkg::CSR_DST_ROWS: dst_rows_ff <= csr_data;
            nns_pkg::CSR_DST_COLS: dst_cols_ff <= csr_data;
            default: ;
         endcase
      end
   end

   nns_map u_map_row (
      .clock (clock),
      .reset (reset),
      .start (map_start),
      .d     (req_row),
      .s     (eff_sr),
      .dn    (eff_dr),
      .done  (row_done),
      .q     (row_q)
   );

   nns_map u_map_col (
      .clock (clock),
      .reset (reset),
      .start (map_start),
      .d     (req_col),
      .s     (eff_sc),
      .dn    (eff_dc),
      .done  (col_done),
      .q     (col_q)
   );

   nns_ram #(
      .WIDTH (nns_pkg::PIX_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (addr_ff),
      .wdata (pix_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nns_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      load_ff    <= load_in;
      y_ff       <= y_in;
      x_ff       <= x_in;
      pix_ff     <= pix_in;
      addr_ff    <= addr_in;
      rsp_pix_ff <= rsp_pix_in;
      rsp_err_ff <= rsp_err_in;
   end

   always_comb begin
      state_in     = state_ff;
      load_in      = load_ff;
      y_in         = y_ff;
      x_in         = x_ff;
      pix_in       = pix_ff;
      addr_in      = addr_ff;
      rsp_valid_in = 1'b0;
      rsp_pix_in   = rsp_pix_ff;
      rsp_err_in   = rsp_err_ff;
      map_start    = 1'b0;
      ram_en       = 1'b0;
      ram_we       = 1'b0;

      unique case (state_ff)
         nns_pkg::ST_IDLE: begin
            if (start) begin
               if (nns_pkg::req_kind_type'(req_type) == nns_pkg::REQ_LOAD) begin
                  if (load_ok) begin
                     y_in     = req_row[nns_pkg::SRC_W-1:0];
                     x_in     = req_col[nns_pkg::SRC_W-1:0];
                     pix_in   = {req_pix_red, req_pix_green, req_pix_blue};
                     load_in  = 1'b1;
                     state_in = nns_pkg::ST_ADDR;
                  end
               end else if (fetch_bad) begin
                  rsp_valid_in = 1'b1;
                  rsp_pix_in   = '0;
                  rsp_err_in   = 1'b1;
               end else begin
                  map_start = 1'b1;
                  load_in   = 1'b0;
                  state_in  = nns_pkg::ST_MAP;
               end
            end
         end
         nns_pkg::ST_MAP: begin
            if (row_done) begin
               y_in     = row_q;
               x_in     = col_q;
               state_in = nns_pkg::ST_ADDR;
            end
         end
         nns_pkg::ST_ADDR: begin
            addr_in  = ADDR_W'(ADDR_W'(y_ff) * COLS_V + ADDR_W'(x_ff));
            state_in = load_ff ? nns_pkg::ST_WRITE : nns_pkg::ST_READ;
         end
         nns_pkg::ST_WRITE: begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            state_in = nns_pkg::ST_IDLE;
         end
         nns_pkg::ST_READ: begin
            ram_en   = 1'b1;
            state_in = nns_pkg::ST_DATA;
         end
         nns_pkg::ST_DATA: begin
            rsp_valid_in = 1'b1;
            rsp_pix_in   = ram_rdata;
            rsp_err_in   = 1'b0;
            state_in     = nns_pkg::ST_IDLE;
         end
         default: begin
            state_in = nns_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy            = state_ff != nns_pkg::ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_blue    = rsp_pix_ff[nns_pkg::CH_W-1:0];
   assign rsp_out_green   = rsp_pix_ff[2*nns_pkg::CH_W-1:nns_pkg::CH_W];
   assign rsp_out_red     = rsp_pix_ff[3*nns_pkg::CH_W-1:2*nns_pkg::CH_W];
   assign rsp_coord_error = rsp_err_ff;

`ifndef ASSERT_OFF
   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      row_done == col_done)
      else $error("row and column mappers out of step");

   a_err_zero_pix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_coord_error |-> rsp_pix_ff == '0)
      else $error("coordinate error transaction carries a pixel");

   a_read_to_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == nns_pkg::ST_READ |=> ##1 rsp_valid && !rsp_coord_error)
      else $error("store read not followed by a response");

   a_map_only_fetch: assert property (@(posedge clock) disable iff (reset)
      state_ff == nns_pkg::ST_MAP |-> !load_ff)
      else $error("mapping started for a load");
`endif

endmodule
